// File: src/trbi_pkg.sv
// shared types, constants and lookup functions for the tuner readout block
package trbi_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SPAN_W          = 10;
	localparam int OFFSET_W        = 14;
	localparam int DUTY_W          = 16;
	localparam int VALUE_W         = 14;
	localparam int QUOT_W          = 10;
	localparam int SEG_W           = 8;
	localparam int DIGIT_W         = 4;
	localparam int POS_W           = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int NUM_DIGITS      = 4;
	localparam int OUT_DATA_W      = SEG_W + DUTY_W;

	// register reset values
	localparam logic [SPAN_W-1:0]   SPAN_RST      = 10'd950;
	localparam logic [OFFSET_W-1:0] OFFSET_RST    = 14'd9000;
	localparam logic [DUTY_W-1:0]   DUTY_A_RST    = 16'd15000;
	localparam logic [DUTY_W-1:0]   DUTY_B_RST    = 16'd3000;
	localparam logic [DUTY_W-1:0]   DUTY_C_RST    = 16'd30000;
	localparam logic [DUTY_W-1:0]   DUTY_IDLE_RST = 16'd100;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;
	localparam logic [SEG_W-1:0]   DP_BIT    = 8'h80;

	// reciprocal of ten: 16-bit scale for values below 16384, 10-bit scale below 100
	localparam int RECIP10_W       = 13;
	localparam int RECIP10_SHIFT   = 16;
	localparam logic [RECIP10_W-1:0] RECIP10 = 13'd6554;
	localparam int RECIP10S_W      = 7;
	localparam int RECIP10S_SHIFT  = 10;
	localparam logic [RECIP10S_W-1:0] RECIP10S = 7'd103;

	typedef logic [VALUE_W-1:0] value_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPAN      = 3'd0,
		CFG_OFFSET    = 3'd1,
		CFG_DUTY_A    = 3'd2,
		CFG_DUTY_B    = 3'd3,
		CFG_DUTY_C    = 3'd4,
		CFG_DUTY_IDLE = 3'd5
	} cfg_index_t;

	typedef enum logic [POS_W-1:0] {
		DIGIT_HUNDREDTHS = 2'd0,
		DIGIT_TENTHS     = 2'd1,
		DIGIT_UNITS      = 2'd2,
		DIGIT_TENS       = 2'd3
	} digit_pos_t;

	// one reading ready for the display scan
	typedef struct packed {
		logic [NUM_DIGITS-1:0][SEG_W-1:0] segs;
		logic [DUTY_W-1:0]                duty;
	} item_t;

	// band edges, half-open ranges in hundredths
	localparam value_t BAND_A_LO [8] = '{14'd9260, 14'd9280, 14'd9340, 14'd9360,
		14'd9820, 14'd9840, 14'd9420, 14'd9440};
	localparam value_t BAND_A_HI [8] = '{14'd9270, 14'd9290, 14'd9350, 14'd9370,
		14'd9830, 14'd9850, 14'd9430, 14'd9450};
	localparam value_t BAND_B_LO [6] = '{14'd9240, 14'd9320, 14'd9800, 14'd9260,
		14'd9370, 14'd9420};
	localparam value_t BAND_B_HI [6] = '{14'd9260, 14'd9340, 14'd9820, 14'd9280,
		14'd9380, 14'd9440};
	localparam value_t BAND_C_LO [4] = '{14'd9270, 14'd9350, 14'd9830, 14'd9430};
	localparam value_t BAND_C_HI [4] = '{14'd9280, 14'd9360, 14'd9840, 14'd9440};

	function automatic logic in_band_a(value_t v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (v >= BAND_A_LO[i] && v < BAND_A_HI[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic in_band_b(value_t v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (v >= BAND_B_LO[i] && v < BAND_B_HI[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic in_band_c(value_t v);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (v >= BAND_C_LO[i] && v < BAND_C_HI[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	// seven-segment pattern, bits 6..0 are g..a
	function automatic logic [SEG_W-1:0] seg_of(logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: src/tuner_readout_and_band_indicator.sv
// top level: sample scaling pipeline, band classification and digit split
//
// Converts one converter sample into a reading in hundredths,
// offset_centi + floor(span_centi * sample / (2^SAMPLE_BITS - 1)), capped at 9999,
// and sends it as four digit beats: hundredths, tenths, units with the decimal
// point, tens (tlast set). tuser carries the digit position, tdata the segment
// pattern and the band PWM compare value, equal on all four beats.
// Samples enter on the s_ group, results leave on the m_ group; registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, with cfg_ready always
// high and unknown indexes dropped. Write registers only while the block is idle.
// Pipeline: six pipeline stages plus the output register lie between an input
// beat and the first beat of its sample.
// Throughput is set by the four-beat scan of the output register; the pipeline
// itself takes a sample every cycle while s_tready is high and buffers up to
// six while the receiver is slow.
// Reset clears all valid bits and loads the register defaults.
// When m_tready is low the output beat holds, the pipeline fills up and then
// s_tready drops; nothing is lost or repeated.
module tuner_readout_and_band_indicator #(
	parameter int SAMPLE_BITS = trbi_pkg::SAMPLE_BITS_DEF,
	parameter int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_DATA_W-1:0]               s_tdata,   // sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [trbi_pkg::OUT_DATA_W-1:0]    m_tdata,   // segments, duty
	output logic [trbi_pkg::POS_W-1:0]         m_tuser,   // digit_position
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [trbi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trbi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import trbi_pkg::*;

	localparam int N     = SAMPLE_BITS;
	localparam int PW    = SPAN_W + N;
	localparam int RW    = ((N > SPAN_W) ? N : SPAN_W) + 1;
	localparam int FULL  = (1 << N) - 1;
	localparam int M10W  = VALUE_W + RECIP10_W;
	localparam int T1_W  = 10;
	localparam int T2_W  = 7;
	localparam int M10BW = T1_W + RECIP10_W;
	localparam int M10CW = T2_W + RECIP10S_W;

	// configuration registers
	logic [SPAN_W-1:0]   span_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [DUTY_W-1:0]   duty_a_q;
	logic [DUTY_W-1:0]   duty_b_q;
	logic [DUTY_W-1:0]   duty_c_q;
	logic [DUTY_W-1:0]   duty_idle_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q      <= SPAN_RST;
			offset_q    <= OFFSET_RST;
			duty_a_q    <= DUTY_A_RST;
			duty_b_q    <= DUTY_B_RST;
			duty_c_q    <= DUTY_C_RST;
			duty_idle_q <= DUTY_IDLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_SPAN:      span_q      <= cfg_data[SPAN_W-1:0];
				CFG_OFFSET:    offset_q    <= cfg_data[OFFSET_W-1:0];
				CFG_DUTY_A:    duty_a_q    <= cfg_data;
				CFG_DUTY_B:    duty_b_q    <= cfg_data;
				CFG_DUTY_C:    duty_c_q    <= cfg_data;
				CFG_DUTY_IDLE: duty_idle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits and advance chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic scan_ready;

	assign en6      = !vld_s6 || scan_ready;
	assign en5      = !vld_s5 || en6;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: span times sample
	logic [PW-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= {{N{1'b0}}, span_q} * {{SPAN_W{1'b0}}, s_tdata[N-1:0]};
		end
	end

	// stage 2: divide by 2^N-1 through folding of the high part
	logic [QUOT_W-1:0] q0;
	logic [RW-1:0]     r0;
	logic [RW-N-1:0]   q1;
	logic [N:0]        r1;
	logic              corr;
	logic [QUOT_W-1:0] quot_s2;

	assign q0   = prod_s1[PW-1:N];
	assign r0   = RW'(prod_s1[N-1:0]) + RW'(q0);
	assign q1   = r0[RW-1:N];
	assign r1   = (N+1)'(r0[N-1:0]) + (N+1)'(q1);
	assign corr = (r1 >= (N+1)'(FULL));

	always_ff @(posedge clk) begin
		if (en2) begin
			quot_s2 <= q0 + QUOT_W'(q1) + QUOT_W'(corr);
		end
	end

	// stage 3: add offset and cap
	logic [OFFSET_W:0] sum;
	value_t            value_s3;

	assign sum = (OFFSET_W+1)'(offset_q) + (OFFSET_W+1)'(quot_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			value_s3 <= (sum > (OFFSET_W+1)'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
		end
	end

	// stage 4: band classification, first digit split
	logic [M10W-1:0]    m10a;
	logic [T1_W-1:0]    t1;
	value_t             rem0;
	logic [DUTY_W-1:0]  duty_sel;
	logic [T1_W-1:0]    t1_s4;
	logic [DIGIT_W-1:0] d0_s4;
	logic [DUTY_W-1:0]  duty_s4;

	assign m10a = M10W'(value_s3) * M10W'(RECIP10);
	assign t1   = m10a[RECIP10_SHIFT +: T1_W];
	assign rem0 = value_s3 - VALUE_W'({t1, 3'b000}) - VALUE_W'({t1, 1'b0});

	always_comb begin
		if (in_band_a(value_s3)) begin
			duty_sel = duty_a_q;
		end else if (in_band_b(value_s3)) begin
			duty_sel = duty_b_q;
		end else if (in_band_c(value_s3)) begin
			duty_sel = duty_c_q;
		end else begin
			duty_sel = duty_idle_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			t1_s4   <= t1;
			d0_s4   <= rem0[DIGIT_W-1:0];
			duty_s4 <= duty_sel;
		end
	end

	// stage 5: tenths digit
	logic [M10BW-1:0]   m10b;
	logic [T2_W-1:0]    t2;
	logic [T1_W-1:0]    rem1;
	logic [T2_W-1:0]    t2_s5;
	logic [DIGIT_W-1:0] d0_s5;
	logic [DIGIT_W-1:0] d1_s5;
	logic [DUTY_W-1:0]  duty_s5;

	assign m10b = M10BW'(t1_s4) * M10BW'(RECIP10);
	assign t2   = m10b[RECIP10_SHIFT +: T2_W];
	assign rem1 = t1_s4 - T1_W'({t2, 3'b000}) - T1_W'({t2, 1'b0});

	always_ff @(posedge clk) begin
		if (en5) begin
			t2_s5   <= t2;
			d0_s5   <= d0_s4;
			d1_s5   <= rem1[DIGIT_W-1:0];
			duty_s5 <= duty_s4;
		end
	end

	// stage 6: units and tens digits, segment patterns
	logic [M10CW-1:0]   m10c;
	logic [DIGIT_W-1:0] d3;
	logic [T2_W-1:0]    rem2;
	item_t              item_s6;

	assign m10c = M10CW'(t2_s5) * M10CW'(RECIP10S);
	assign d3   = m10c[RECIP10S_SHIFT +: DIGIT_W];
	assign rem2 = t2_s5 - T2_W'({d3, 3'b000}) - T2_W'({d3, 1'b0});

	always_ff @(posedge clk) begin
		if (en6) begin
			item_s6.segs[DIGIT_HUNDREDTHS] <= seg_of(d0_s5);
			item_s6.segs[DIGIT_TENTHS]     <= seg_of(d1_s5);
			item_s6.segs[DIGIT_UNITS]      <= seg_of(rem2[DIGIT_W-1:0]) | DP_BIT;
			item_s6.segs[DIGIT_TENS]       <= seg_of(d3);
			item_s6.duty                   <= duty_s5;
		end
	end

	// four-beat display scan
	trbi_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s6),
		.in_ready (scan_ready),
		.in_item  (item_s6),
		.tvalid   (m_tvalid),
		.tready   (m_tready),
		.tdata    (m_tdata),
		.tuser    (m_tuser),
		.tlast    (m_tlast)
	);

	// checks
	a_last_on_tens: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == DIGIT_TENS)))
		else $error("tlast not on the tens digit");

	a_dp_on_units: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[SEG_W-1] == (m_tuser == DIGIT_UNITS)))
		else $error("decimal point off the units digit");

	a_digit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && (m_tuser == POS_W'($past(m_tuser) + 2'd1))))
		else $error("digit sequence broken inside a reading");

	a_duty_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tdata[OUT_DATA_W-1:SEG_W] == $past(m_tdata[OUT_DATA_W-1:SEG_W])))
		else $error("duty changed within a reading");

endmodule

// File: src/trbi_scan.sv
// output register that plays one reading out as four digit beats
module trbi_scan (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  trbi_pkg::item_t                       in_item,
	output logic                                  tvalid,
	input  logic                                  tready,
	output logic [trbi_pkg::OUT_DATA_W-1:0]       tdata,  // segments, duty
	output logic [trbi_pkg::POS_W-1:0]            tuser,  // digit_position
	output logic                                  tlast
);
	import trbi_pkg::*;

	logic       valid_q;
	item_t      item_q;
	digit_pos_t pos_q;
	logic       beat_done;
	logic       item_done;

	assign beat_done = valid_q && tready;
	assign item_done = beat_done && (pos_q == DIGIT_TENS);
	assign in_ready  = !valid_q || item_done;

	// hold state and digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= DIGIT_HUNDREDTHS;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
				pos_q   <= DIGIT_HUNDREDTHS;
			end else if (beat_done) begin
				pos_q <= digit_pos_t'(pos_q + 2'd1);
			end
		end
	end

	// held reading
	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_q <= in_item;
		end
	end

	assign tvalid = valid_q;
	assign tuser  = pos_q;
	assign tlast  = (pos_q == DIGIT_TENS);
	assign tdata  = {item_q.duty, item_q.segs[pos_q]};

endmodule

// File: dv/tuner_readout_chk.sv
// checker for the tuner readout: predicts the four digit beats of each sample and compares them
`timescale 1ns / 100ps
module tuner_readout_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // sample
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [trbi_pkg::OUT_DATA_W-1:0] m_tdata,   // segments, duty
	input  logic [trbi_pkg::POS_W-1:0]      m_tuser,   // digit_position
	input  logic                            m_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [trbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trbi_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import trbi_pkg::*;

	localparam int CODE_TOP    = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int READING_TOP = 9999;
	localparam logic [SEG_W-1:0] POINT_SEG = 8'h80;

	// segment patterns for 0..9, bits 6..0 are g..a
	localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

	// frequency bands in hundredths, lower edge included, upper edge excluded
	localparam int NEAR_LO [8] = '{9260, 9280, 9340, 9360, 9820, 9840, 9420, 9440};
	localparam int NEAR_HI [8] = '{9270, 9290, 9350, 9370, 9830, 9850, 9430, 9450};
	localparam int ADJ_LO  [6] = '{9240, 9320, 9800, 9260, 9370, 9420};
	localparam int ADJ_HI  [6] = '{9260, 9340, 9820, 9280, 9380, 9440};
	localparam int STN_LO  [4] = '{9270, 9350, 9830, 9430};
	localparam int STN_HI  [4] = '{9280, 9360, 9840, 9440};

	typedef struct {
		digit_pos_t        pos;
		logic [SEG_W-1:0]  seg;
		logic [DUTY_W-1:0] duty;
		logic              tail;
	} digit_beat_t;

	digit_beat_t digit_beats_q [$];

	// own copy of the register file
	logic [SPAN_W-1:0]   span_r;
	logic [OFFSET_W-1:0] offset_r;
	logic [DUTY_W-1:0]   duty_near_r;
	logic [DUTY_W-1:0]   duty_adj_r;
	logic [DUTY_W-1:0]   duty_stn_r;
	logic [DUTY_W-1:0]   duty_idle_r;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic log_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
	endtask

	// band priority: near station first, then adjacent, then on station, else idle
	function automatic logic [DUTY_W-1:0] band_duty(input int reading);
		bit hit_near;
		bit hit_adj;
		bit hit_stn;
		hit_near = 1'b0;
		hit_adj  = 1'b0;
		hit_stn  = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (reading >= NEAR_LO[i] && reading < NEAR_HI[i]) hit_near = 1'b1;
		end
		for (int i = 0; i < 6; i++) begin
			if (reading >= ADJ_LO[i] && reading < ADJ_HI[i]) hit_adj = 1'b1;
		end
		for (int i = 0; i < 4; i++) begin
			if (reading >= STN_LO[i] && reading < STN_HI[i]) hit_stn = 1'b1;
		end
		if (hit_near) return duty_near_r;
		else if (hit_adj) return duty_adj_r;
		else if (hit_stn) return duty_stn_r;
		else return duty_idle_r;
	endfunction

	// scale one sample to hundredths and queue its four digit beats
	function automatic void queue_reading(input logic [SAMPLE_BITS_DEF-1:0] smp);
		int reading;
		int rest;
		logic [DUTY_W-1:0] duty;
		digit_beat_t b;
		reading = int'(offset_r) + (int'(span_r) * int'(smp)) / CODE_TOP;
		if (reading > READING_TOP) reading = READING_TOP;
		duty = band_duty(reading);
		rest = reading;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			b.pos  = digit_pos_t'(k);
			b.seg  = DIGIT_SEGS[rest % 10];
			if (b.pos == DIGIT_UNITS) b.seg = b.seg | POINT_SEG;
			b.duty = duty;
			b.tail = (b.pos == DIGIT_TENS);
			digit_beats_q.push_back(b);
			rest = rest / 10;
		end
	endfunction

	// register writes, sample beats and digit beats, all seen at the rising edge
	always @(posedge clk or negedge arst_n) begin
		digit_beat_t want;
		if (!arst_n) begin
			span_r      = 10'd950;
			offset_r    = 14'd9000;
			duty_near_r = 16'd15000;
			duty_adj_r  = 16'd3000;
			duty_stn_r  = 16'd30000;
			duty_idle_r = 16'd100;
			digit_beats_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPAN:      span_r      = cfg_data[SPAN_W-1:0];
					CFG_OFFSET:    offset_r    = cfg_data[OFFSET_W-1:0];
					CFG_DUTY_A:    duty_near_r = cfg_data;
					CFG_DUTY_B:    duty_adj_r  = cfg_data;
					CFG_DUTY_C:    duty_stn_r  = cfg_data;
					CFG_DUTY_IDLE: duty_idle_r = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) queue_reading(s_tdata[SAMPLE_BITS_DEF-1:0]);
			if (m_tvalid && m_tready) begin
				if (digit_beats_q.size() == 0) begin
					log_mismatch("unexpected digit beat", 32'(m_tuser), 32'd0);
				end else begin
					want = digit_beats_q.pop_front();
					if (m_tuser !== want.pos)
						log_mismatch("digit position", 32'(m_tuser), 32'(want.pos));
					if (m_tdata[SEG_W-1:0] !== want.seg)
						log_mismatch("segments", 32'(m_tdata[SEG_W-1:0]), 32'(want.seg));
					if (m_tdata[SEG_W +: DUTY_W] !== want.duty)
						log_mismatch("duty", 32'(m_tdata[SEG_W +: DUTY_W]), 32'(want.duty));
					if (m_tlast !== want.tail)
						log_mismatch("last", 32'(m_tlast), 32'(want.tail));
				end
			end
			pending = digit_beats_q.size();
		end
	end

endmodule

// File: dv/tb_tuner_readout_and_band_indicator.sv
// testbench top for the tuner readout: clock, reset, sample and register stimulus, verdict
`timescale 1ns / 100ps
module tb_tuner_readout_and_band_indicator;
	import trbi_pkg::*;

	localparam int IN_W            = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int CODE_TOP        = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int NUM_PHASES      = 6;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 3000;
	localparam int SETTLE_CYCLES   = 20;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// band edges worth aiming at
	localparam int EDGE_MARKS [20] = '{9240, 9260, 9270, 9280, 9290, 9320, 9340, 9350, 9360,
		9370, 9380, 9420, 9430, 9440, 9450, 9800, 9820, 9830, 9840, 9850};
	// one reading in each band, both overlaps and one outside all bands
	localparam int DIRECTED_MARKS [7] = '{9265, 9250, 9270, 9355, 9435, 9830, 9100};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [POS_W-1:0]      m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int gap_pct;
	int stall_pct;
	int hold_left;
	int quiet_cycles;
	int unsigned cur_span;
	int unsigned cur_offset;
	logic hold_go;

	tuner_readout_and_band_indicator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tuner_readout_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver: long hold-off on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog on cycles with no beat moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == CFG_SPAN) cur_span = data[SPAN_W-1:0];
		if (idx == CFG_OFFSET) cur_offset = data[OFFSET_W-1:0];
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] smp);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - SAMPLE_BITS_DEF){1'b0}}, smp};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// wait until every digit beat has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// smallest sample that lands on the given reading, random if out of reach
	function automatic logic [SAMPLE_BITS_DEF-1:0] sample_for(input int unsigned target);
		int unsigned k;
		if (cur_span == 0 || target < cur_offset || target - cur_offset > cur_span)
			return SAMPLE_BITS_DEF'($urandom_range(0, CODE_TOP));
		k = target - cur_offset;
		return SAMPLE_BITS_DEF'((k * CODE_TOP + cur_span - 1) / cur_span);
	endfunction

	// mostly band edges, some extremes, the rest uniform
	function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return r[0] ? SAMPLE_BITS_DEF'(CODE_TOP) : '0;
		if (r < 65) return sample_for(EDGE_MARKS[$urandom_range(0, 19)] - $urandom_range(0, 1));
		return SAMPLE_BITS_DEF'($urandom_range(0, CODE_TOP));
	endfunction

	// register settings per phase, extremes included
	task automatic apply_settings(input int phase);
		logic [CFG_DATA_W-1:0] span_d;
		logic [CFG_DATA_W-1:0] offset_d;
		logic [CFG_DATA_W-1:0] duty_d [4];
		for (int i = 0; i < 4; i++) duty_d[i] = CFG_DATA_W'($urandom_range(0, 65535));
		case (phase)
			0: begin
				span_d   = 16'd1023;
				offset_d = 16'd9000;
				write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
				write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
			end
			1: begin
				span_d   = 16'd0;
				offset_d = 16'd9999;
				for (int i = 0; i < 4; i++) duty_d[i] = 16'h0000;
			end
			2: begin
				// all ones: span and offset keep only their low bits, sum saturates
				span_d   = 16'hFFFF;
				offset_d = 16'hFFFF;
				for (int i = 0; i < 4; i++) duty_d[i] = 16'hFFFF;
			end
			3: begin
				span_d   = 16'd1023;
				offset_d = 16'd9200;
			end
			4: begin
				span_d   = 16'd512;
				offset_d = 16'd9300;
			end
			default: begin
				span_d   = 16'd1;
				offset_d = 16'd0;
			end
		endcase
		write_reg(CFG_SPAN, span_d);
		write_reg(CFG_OFFSET, offset_d);
		write_reg(CFG_DUTY_A, duty_d[0]);
		write_reg(CFG_DUTY_B, duty_d[1]);
		write_reg(CFG_DUTY_C, duty_d[2]);
		write_reg(CFG_DUTY_IDLE, duty_d[3]);
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		hold_go      = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		gap_pct      = 0;
		stall_pct    = 0;
		cur_span     = 950;
		cur_offset   = 9000;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero, full scale, walking ones, then band readings at reset settings
		send_sample('0);
		send_sample(SAMPLE_BITS_DEF'(CODE_TOP));
		for (int i = 0; i < SAMPLE_BITS_DEF; i++) send_sample(SAMPLE_BITS_DEF'(1 << i));
		foreach (DIRECTED_MARKS[i]) send_sample(sample_for(DIRECTED_MARKS[i]));

		// random phases: sender idles less, then receiver idles less, then no idling
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			apply_settings(p);
			case (p / 2)
				0: begin
					gap_pct   = 33;
					stall_pct = 68;
				end
				1: begin
					gap_pct   = 68;
					stall_pct = 33;
				end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
			endcase
			// long receiver hold-off while samples keep coming
			if (p == PRESSURE_PHASE) begin
				hold_go <= 1'b1;
				@(negedge clk);
				hold_go <= 1'b0;
			end
			repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
src/trbi_pkg.sv
src/trbi_scan.sv
src/tuner_readout_and_band_indicator.sv
dv/tuner_readout_chk.sv
dv/tb_tuner_readout_and_band_indicator.sv
